@@ hw/rtl/orne_pkg.sv @@
// Shared types and constants for the object record name extractor.
package orne_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_NAME_CHAR = 2'd0;
    localparam logic [1:0] KIND_NAME_DONE = 2'd1;
    localparam logic [1:0] KIND_FILE_OK   = 2'd2;
    localparam logic [1:0] KIND_FILE_ERR  = 2'd3;

    // Error codes carried with a file error.
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_NOT_OMF       = 3'd1;
    localparam logic [2:0] ERR_HEADER_LEN    = 3'd2;
    localparam logic [2:0] ERR_COMMENT_SMALL = 3'd3;
    localparam logic [2:0] ERR_RESERVED_FLAG = 3'd4;
    localparam logic [2:0] ERR_DEP_LEN       = 3'd5;
    localparam logic [2:0] ERR_EOF           = 3'd6;

    // Record types and comment class of interest.
    localparam logic [7:0] REC_THEADR    = 8'h80;
    localparam logic [7:0] REC_LHEADR    = 8'h82;
    localparam logic [7:0] REC_COMMENT   = 8'h88;
    localparam logic [7:0] CLASS_DEP     = 8'he9;
    localparam logic [7:0] FLAG_RESERVED = 8'h3f;

    // Length of a dependency record that marks the end of the list.
    localparam logic [15:0] DEP_END_LEN = 16'd3;

    // Depth of the result queue; a byte yields at most two results.
    localparam int RESULT_DEPTH   = 4;
    localparam int RESULTS_PER_IN = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic [7:0] name_length;
        logic [2:0] error_code;
    } result_t;

endpackage

@@ hw/rtl/orne_parser.sv @@
// Record walker: per-byte state update and result generation.
module orne_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_value,
    input  logic                last_byte,
    output orne_pkg::result_t   res0,
    output orne_pkg::result_t   res1,
    output logic [1:0]          res_count
);

    typedef enum logic [1:0] {PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_BODY} phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  class_reg, class_next;
    logic [2:0]  fault_reg, fault_next;
    logic        first_reg, first_next;
    logic        finished_reg, finished_next;

    // Values of this byte before the end-of-record check.
    logic [15:0] len_mid;
    logic [7:0]  count_mid;
    logic [7:0]  class_mid;
    logic [2:0]  fault_mid;
    logic        is_hdr;
    logic        is_cmt;
    logic        emit_char;
    logic        do_end;
    logic        do_cut;
    logic        clear_file;
    logic [16:0] pos_inc;

    // End-of-record results.
    logic [2:0]  end_fault;
    logic        dep_end;
    logic        end_done;
    orne_pkg::result_t e0, e1;
    logic [1:0]  e_count;

    function automatic orne_pkg::result_t mk(input logic [1:0] k, input logic [7:0] c,
                                             input logic [7:0] l, input logic [2:0] e);
        orne_pkg::result_t r;
        r.kind        = k;
        r.char_value  = c;
        r.name_length = l;
        r.error_code  = e;
        return r;
    endfunction

    assign is_hdr  = (type_reg == orne_pkg::REC_THEADR) || (type_reg == orne_pkg::REC_LHEADR);
    assign is_cmt  = type_reg == orne_pkg::REC_COMMENT;
    assign pos_inc = {1'b0, pos_reg} + 17'd1;

    // Length high byte and body byte checks.
    always_comb
    begin
        len_mid   = len_reg;
        count_mid = count_reg;
        class_mid = class_reg;
        fault_mid = fault_reg;
        emit_char = 1'b0;
        if (phase_reg == PH_LEN_HI)
        begin
            len_mid = {byte_value, len_reg[7:0]};
        end
        else if (phase_reg == PH_BODY)
        begin
            if (is_hdr && fault_reg == orne_pkg::ERR_NONE)
            begin
                if (pos_reg == 16'd0)
                begin
                    count_mid = byte_value;
                    if ({8'd0, byte_value} + 16'd2 != len_reg)
                        fault_mid = first_reg ? orne_pkg::ERR_NOT_OMF : orne_pkg::ERR_HEADER_LEN;
                end
                else if (pos_reg <= {8'd0, count_reg})
                begin
                    emit_char = 1'b1;
                end
            end
            else if (is_cmt && fault_reg == orne_pkg::ERR_NONE)
            begin
                if (pos_reg == 16'd0)
                begin
                    if (len_reg >= 16'd2 && (byte_value & orne_pkg::FLAG_RESERVED) != 8'd0)
                        fault_mid = orne_pkg::ERR_RESERVED_FLAG;
                end
                else if (pos_reg == 16'd1)
                begin
                    class_mid = byte_value;
                end
                else if (class_reg == orne_pkg::CLASS_DEP)
                begin
                    if (pos_reg == 16'd6)
                    begin
                        count_mid = byte_value;
                        if ({8'd0, byte_value} + 16'd8 != len_reg)
                            fault_mid = orne_pkg::ERR_DEP_LEN;
                    end
                    else if (pos_reg >= 16'd7 && pos_reg <= {8'd0, count_reg} + 16'd6)
                    begin
                        emit_char = 1'b1;
                    end
                end
            end
        end
    end

    // Record verdict, used when this byte closes a record.
    always_comb
    begin
        end_fault = fault_mid;
        dep_end   = 1'b0;
        end_done  = 1'b0;
        e0        = mk(orne_pkg::KIND_NAME_CHAR, 8'd0, 8'd0, orne_pkg::ERR_NONE);
        e1        = e0;
        e_count   = 2'd0;
        if (end_fault == orne_pkg::ERR_NONE && is_hdr && len_mid < 16'd2)
            end_fault = first_reg ? orne_pkg::ERR_NOT_OMF : orne_pkg::ERR_HEADER_LEN;
        if (end_fault == orne_pkg::ERR_NONE && is_cmt && len_mid < 16'd2)
            end_fault = orne_pkg::ERR_COMMENT_SMALL;
        if (end_fault == orne_pkg::ERR_NONE && is_cmt && class_mid == orne_pkg::CLASS_DEP
            && len_mid < 16'd7)
        begin
            if (len_mid == orne_pkg::DEP_END_LEN)
                dep_end = 1'b1;
            else
                end_fault = orne_pkg::ERR_DEP_LEN;
        end
        if (end_fault != orne_pkg::ERR_NONE)
        begin
            e0       = mk(orne_pkg::KIND_FILE_ERR, 8'd0, 8'd0, end_fault);
            e_count  = 2'd1;
            end_done = 1'b1;
        end
        else if (dep_end)
        begin
            e0       = mk(orne_pkg::KIND_FILE_OK, 8'd0, 8'd0, orne_pkg::ERR_NONE);
            e_count  = 2'd1;
            end_done = 1'b1;
        end
        else if (first_reg && last_byte)
        begin
            e0       = mk(orne_pkg::KIND_FILE_ERR, 8'd0, 8'd0, orne_pkg::ERR_NOT_OMF);
            e_count  = 2'd1;
            end_done = 1'b1;
        end
        else if (is_hdr || (is_cmt && class_mid == orne_pkg::CLASS_DEP))
        begin
            e0      = mk(orne_pkg::KIND_NAME_DONE, 8'd0, count_mid, orne_pkg::ERR_NONE);
            e1      = mk(orne_pkg::KIND_FILE_OK, 8'd0, 8'd0, orne_pkg::ERR_NONE);
            e_count = last_byte ? 2'd2 : 2'd1;
        end
        else
        begin
            e0      = mk(orne_pkg::KIND_FILE_OK, 8'd0, 8'd0, orne_pkg::ERR_NONE);
            e_count = last_byte ? 2'd1 : 2'd0;
        end
    end

    // Next state and result slots.
    always_comb
    begin
        phase_next    = phase_reg;
        type_next     = type_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        class_next    = class_reg;
        fault_next    = fault_reg;
        first_next    = first_reg;
        finished_next = finished_reg;
        do_end        = 1'b0;
        do_cut        = 1'b0;
        clear_file    = 1'b0;
        res0          = mk(orne_pkg::KIND_NAME_CHAR, 8'd0, 8'd0, orne_pkg::ERR_NONE);
        res1          = res0;
        res_count     = 2'd0;

        if (finished_reg)
        begin
            clear_file = last_byte;
        end
        else
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    type_next  = byte_value;
                    len_next   = 16'd0;
                    pos_next   = 16'd0;
                    count_next = 8'd0;
                    class_next = 8'd0;
                    fault_next = (first_reg && byte_value != orne_pkg::REC_THEADR
                                  && byte_value != orne_pkg::REC_LHEADR)
                                 ? orne_pkg::ERR_NOT_OMF : orne_pkg::ERR_NONE;
                    phase_next = PH_LEN_LO;
                    do_cut     = last_byte;
                end
                PH_LEN_LO:
                begin
                    len_next   = {8'd0, byte_value};
                    phase_next = PH_LEN_HI;
                    do_cut     = last_byte;
                end
                PH_LEN_HI:
                begin
                    len_next = len_mid;
                    if (len_mid == 16'd0)
                    begin
                        do_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        do_cut     = last_byte;
                    end
                end
                PH_BODY:
                begin
                    count_next = count_mid;
                    class_next = class_mid;
                    fault_next = fault_mid;
                    if (pos_inc >= {1'b0, len_reg})
                    begin
                        do_end = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc[15:0];
                        do_cut   = last_byte;
                    end
                end
                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase

            if (emit_char)
            begin
                res0      = mk(orne_pkg::KIND_NAME_CHAR, byte_value, 8'd0, orne_pkg::ERR_NONE);
                res_count = 2'd1;
            end

            if (do_cut)
            begin
                if (emit_char)
                    res1 = mk(orne_pkg::KIND_FILE_ERR, 8'd0, 8'd0,
                              first_reg ? orne_pkg::ERR_NOT_OMF : orne_pkg::ERR_EOF);
                else
                    res0 = mk(orne_pkg::KIND_FILE_ERR, 8'd0, 8'd0,
                              first_reg ? orne_pkg::ERR_NOT_OMF : orne_pkg::ERR_EOF);
                res_count  = res_count + 2'd1;
                clear_file = 1'b1;
            end
            else if (do_end)
            begin
                // A closing byte never carries a name character as well as two verdicts.
                if (emit_char)
                begin
                    res1      = e0;
                    res_count = res_count + ((e_count != 2'd0) ? 2'd1 : 2'd0);
                end
                else
                begin
                    res0      = e0;
                    res1      = e1;
                    res_count = e_count;
                end
                if (!end_done)
                    first_next = 1'b0;
                if (last_byte)
                    clear_file = 1'b1;
                else if (end_done)
                    finished_next = 1'b1;
                else
                    phase_next = PH_TYPE;
            end
        end

        if (clear_file)
        begin
            phase_next    = PH_TYPE;
            type_next     = 8'd0;
            len_next      = 16'd0;
            pos_next      = 16'd0;
            count_next    = 8'd0;
            class_next    = 8'd0;
            fault_next    = orne_pkg::ERR_NONE;
            first_next    = 1'b1;
            finished_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TYPE;
            type_reg     <= 8'd0;
            len_reg      <= 16'd0;
            pos_reg      <= 16'd0;
            count_reg    <= 8'd0;
            class_reg    <= 8'd0;
            fault_reg    <= orne_pkg::ERR_NONE;
            first_reg    <= 1'b1;
            finished_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            type_reg     <= type_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            class_reg    <= class_next;
            fault_reg    <= fault_next;
            first_reg    <= first_next;
            finished_reg <= finished_next;
        end
    end

`ifndef ASSERT_OFF
    // A second result of one byte is always a verdict, never a name character.
    a_second_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_count == 2'd2) |-> (res1.kind != orne_pkg::KIND_NAME_CHAR))
        else $error("second result of a byte is a name character");
`endif

endmodule

@@ hw/rtl/orne_result_queue.sv @@
// Small result queue: takes up to two results a cycle, hands out one.
module orne_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  orne_pkg::result_t   push0,
    input  orne_pkg::result_t   push1,
    input  logic [1:0]          push_count,
    input  logic                pop,
    output orne_pkg::result_t   head,
    output logic                not_empty,
    output logic                has_room
);

    localparam int PtrW = $clog2(orne_pkg::RESULT_DEPTH);
    localparam int CntW = $clog2(orne_pkg::RESULT_DEPTH + 1);

    orne_pkg::result_t entry_reg [orne_pkg::RESULT_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [PtrW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PtrW'(1);
    assign head         = entry_reg[rd_ptr_reg];
    assign not_empty    = count_reg != CntW'(0);
    assign has_room     = count_reg <= CntW'(orne_pkg::RESULT_DEPTH - orne_pkg::RESULTS_PER_IN);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + CntW'(push_count) - (pop ? CntW'(1) : CntW'(0));
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_count != 2'd0 |-> ({1'b0, count_reg} + (CntW+1)'(push_count)
                                <= (CntW+1)'(orne_pkg::RESULT_DEPTH)))
        else $error("result queue overflow");
    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CntW'(orne_pkg::RESULT_DEPTH)) |->
            (PtrW'(wr_ptr_reg - rd_ptr_reg) == count_reg[PtrW-1:0]))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

@@ hw/rtl/omf_record_name_extractor.sv @@
// Top level of the object record name extractor: input stage, parser and result queue.
// Flow: an accepted byte waits in the input stage register and is parsed once the queue
//   has room; its results are written into the result queue, a second behind the first.
// Throughput: one byte per cycle; two-result bytes are absorbed by the four-entry queue,
//   and the input stalls only while three or more results wait in it.
// Reset (rst_n, asynchronous, active low) empties both stages and readies the parser.
module omf_record_name_extractor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] kind,
    output logic [7:0] char_value,
    output logic [7:0] name_length,
    output logic [2:0] error_code
);

    // Input stage: one registered beat waiting to be parsed.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic              step;
    logic              accept;
    logic              pop;
    logic              queue_room;
    orne_pkg::result_t res0;
    orne_pkg::result_t res1;
    logic [1:0]        res_count;
    orne_pkg::result_t head;

    // The held beat is parsed as soon as the queue can take both of its possible results.
    assign step       = in_valid_reg && queue_room;
    // The input stage frees up in the same cycle that it is parsed, so a new beat can
    // enter every cycle while the queue has room.
    assign byte_stall = in_valid_reg && !queue_room;
    assign accept     = byte_valid && !byte_stall;
    assign pop        = result_valid && !result_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= byte_value;
            in_last_reg <= last_byte;
        end
    end

    orne_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    orne_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (res0),
        .push1      (res1),
        .push_count (step ? res_count : 2'd0),
        .pop        (pop),
        .head       (head),
        .not_empty  (result_valid),
        .has_room   (queue_room)
    );

    // The head entry only moves on a pop, so a stalled result beat holds.
    assign kind        = head.kind;
    assign char_value  = head.char_value;
    assign name_length = head.name_length;
    assign error_code  = head.error_code;

`ifndef ASSERT_OFF
    // A held beat that is stalled is still there in the next cycle.
    a_held_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && byte_stall) |=> in_valid_reg)
        else $error("stalled input beat lost");
    // A held beat is never replaced by a new one unless it is parsed in the same cycle.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_valid_reg) |-> step)
        else $error("unparsed input beat overwritten");
`endif

endmodule
